// File: design/ffsa_pkg.sv
// Shared constants, types and codes for the first-fit segment allocator.
package ffsa_pkg;

    // Table sizes and internal address width
    localparam int FREE_ENTRIES = 16;
    localparam int USED_ENTRIES = 16;
    localparam int ADDR_BITS    = 32;

    // Fixed field widths on the stream ports
    localparam int OWNER_W      = 16;
    localparam int FIELD_ADDR_W = 32;
    localparam int SIZE_W       = 32;
    localparam int STATUS_W     = 3;

    localparam int IN_DATA_W    = 80;
    localparam int OUT_FIELDS_W = 1 + FIELD_ADDR_W + STATUS_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    // Index and count widths
    localparam int FIDX_W = $clog2(FREE_ENTRIES);
    localparam int UIDX_W = $clog2(USED_ENTRIES);
    localparam int FCNT_W = $clog2(FREE_ENTRIES + 1);
    localparam int UCNT_W = $clog2(USED_ENTRIES + 1);

    // Command kinds carried in tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_OWNER = 3'd1,
        ST_ZERO_SIZE = 3'd2,
        ST_NO_FIT    = 3'd3,
        ST_USED_FULL = 3'd4,
        ST_FREE_FULL = 3'd5
    } status_t;

    // One free table entry
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    length;
    } free_entry_t;

    // One occupied table entry
    typedef struct packed {
        logic [OWNER_W-1:0]   owner;
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    length;
    } used_entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;      // latch the accepted transaction
        logic    load_store;   // append loaded segment to free table
        logic    scan_next;    // advance free scan index
        logic    hit_take;     // latch grant and shrunk entry
        logic    free_update;  // write shrunk entry back
        logic    free_step;    // advance close-up index
        logic    free_move;    // move entry one place down
        logic    free_dec;     // drop one free entry
        logic    uscan_next;   // advance occupied scan index
        logic    pos_take;     // latch insert position, start shift at top
        logic    ushift;       // move occupied entry one place up
        logic    uins;         // write new occupied entry
        logic    set_result;   // latch result fields
        logic    res_granted;
        status_t res_status;
        logic    out_load;     // move result into output register
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_alloc;
        logic owner_zero;
        logic size_zero;
        logic free_full;
        logic free_empty;
        logic used_full;
        logic fit;
        logic scan_last;
        logic nlen_zero;
        logic used_end;
        logic used_greater;
        logic at_pos;
        logic out_free;
    } dp_stat_t;

endpackage

// File: design/ffsa_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: design/ffsa_ctrl.sv
// Sequencing state machine for load and allocate transactions.
module ffsa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffsa_pkg::dp_stat_t  stat,
    output ffsa_pkg::ctl_cmd_t  cmd
);
    import ffsa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHECK  = 9'b000000010,
        S_SCAN   = 9'b000000100,
        S_FUPD   = 9'b000001000,
        S_FSHIFT = 9'b000010000,
        S_USCAN  = 9'b000100000,
        S_USHIFT = 9'b001000000,
        S_UINS   = 9'b010000000,
        S_RESP   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.is_alloc)
                begin
                    cmd.set_result = 1'b1;
                    state_next     = S_RESP;
                    if (stat.size_zero)
                    begin
                        cmd.res_status = ST_ZERO_SIZE;
                    end
                    else if (stat.free_full)
                    begin
                        cmd.res_status = ST_FREE_FULL;
                    end
                    else
                    begin
                        cmd.load_store = 1'b1;
                    end
                end
                else if (stat.owner_zero)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_BAD_OWNER;
                    state_next     = S_RESP;
                end
                else if (stat.size_zero)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_ZERO_SIZE;
                    state_next     = S_RESP;
                end
                else if (stat.free_empty)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_NO_FIT;
                    state_next     = S_RESP;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.fit)
                begin
                    if (stat.used_full)
                    begin
                        cmd.set_result = 1'b1;
                        cmd.res_status = ST_USED_FULL;
                        state_next     = S_RESP;
                    end
                    else
                    begin
                        cmd.hit_take = 1'b1;
                        state_next   = S_FUPD;
                    end
                end
                else if (stat.scan_last)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_NO_FIT;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_FUPD:
            begin
                if (!stat.nlen_zero)
                begin
                    cmd.free_update = 1'b1;
                    state_next      = S_USCAN;
                end
                else if (stat.scan_last)
                begin
                    cmd.free_dec = 1'b1;
                    state_next   = S_USCAN;
                end
                else
                begin
                    cmd.free_step = 1'b1;
                    state_next    = S_FSHIFT;
                end
            end
            S_FSHIFT:
            begin
                cmd.free_move = 1'b1;
                if (stat.scan_last)
                begin
                    cmd.free_dec = 1'b1;
                    state_next   = S_USCAN;
                end
                else
                begin
                    cmd.free_step = 1'b1;
                end
            end
            S_USCAN:
            begin
                if (stat.used_end)
                begin
                    cmd.pos_take = 1'b1;
                    state_next   = S_UINS;
                end
                else if (stat.used_greater)
                begin
                    cmd.pos_take = 1'b1;
                    state_next   = S_USHIFT;
                end
                else
                begin
                    cmd.uscan_next = 1'b1;
                end
            end
            S_USHIFT:
            begin
                cmd.ushift = 1'b1;
                if (stat.at_pos)
                begin
                    state_next = S_UINS;
                end
            end
            S_UINS:
            begin
                cmd.uins        = 1'b1;
                cmd.set_result  = 1'b1;
                cmd.res_granted = 1'b1;
                cmd.res_status  = ST_OK;
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/ffsa_dp.sv
// Datapath: transaction registers, table RAMs, indexes, counts and output register.
module ffsa_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_command,
    input  logic [ffsa_pkg::IN_DATA_W-1:0]      in_data,
    input  ffsa_pkg::ctl_cmd_t                  cmd,
    output ffsa_pkg::dp_stat_t                  stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ffsa_pkg::OUT_DATA_W-1:0]     out_data
);
    import ffsa_pkg::*;

    // transaction registers
    logic                 cmd_reg;
    logic [OWNER_W-1:0]   owner_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [SIZE_W-1:0]    size_reg;

    // table bookkeeping
    logic [FCNT_W-1:0]    fcount_reg;
    logic [UCNT_W-1:0]    ucount_reg;
    logic [FIDX_W-1:0]    idx_reg, idx_next;
    logic [UIDX_W-1:0]    uidx_reg, uidx_next;
    logic [UIDX_W-1:0]    pos_reg;
    logic [ADDR_BITS-1:0] grant_reg;
    logic [ADDR_BITS-1:0] nstart_reg;
    logic [SIZE_W-1:0]    nlen_reg;

    // result and output registers
    logic                 res_granted_reg;
    status_t              res_status_reg;
    logic                 out_valid_reg;
    logic                 out_granted_reg;
    logic [FIELD_ADDR_W-1:0] out_addr_reg;
    status_t              out_status_reg;

    // RAM ports
    logic                 fw_en;
    logic [FIDX_W-1:0]    fw_addr;
    free_entry_t          fw_data;
    logic [$bits(free_entry_t)-1:0] frd_bits;
    free_entry_t          frd;
    logic                 uw_en;
    logic [UIDX_W-1:0]    uw_addr;
    used_entry_t          uw_data;
    logic [$bits(used_entry_t)-1:0] urd_bits;
    used_entry_t          urd;

    assign frd = free_entry_t'(frd_bits);
    assign urd = used_entry_t'(urd_bits);

    // transaction capture; tdata is owner, address, size from the low bits up
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= in_command;
            owner_reg <= in_data[OWNER_W-1:0];
            addr_reg  <= ADDR_BITS'(in_data[OWNER_W +: FIELD_ADDR_W]);
            size_reg  <= in_data[OWNER_W + FIELD_ADDR_W +: SIZE_W];
        end
    end

    // scan indexes; the read address follows the next index so read data
    // always matches the current index
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.capture)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_next || cmd.free_step)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        uidx_next = uidx_reg;
        if (cmd.capture)
        begin
            uidx_next = '0;
        end
        else if (cmd.uscan_next)
        begin
            uidx_next = uidx_reg + 1'b1;
        end
        else if (cmd.pos_take)
        begin
            uidx_next = UIDX_W'(ucount_reg - 1'b1);
        end
        else if (cmd.ushift)
        begin
            uidx_next = uidx_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            uidx_reg      <= '0;
            fcount_reg    <= '0;
            ucount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            uidx_reg <= uidx_next;
            if (cmd.load_store)
            begin
                fcount_reg <= fcount_reg + 1'b1;
            end
            else if (cmd.free_dec)
            begin
                fcount_reg <= fcount_reg - 1'b1;
            end
            if (cmd.uins)
            begin
                ucount_reg <= ucount_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hit, insert position and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.hit_take)
        begin
            grant_reg  <= frd.start;
            nstart_reg <= frd.start + ADDR_BITS'(size_reg);
            nlen_reg   <= frd.length - size_reg;
        end
        if (cmd.pos_take)
        begin
            pos_reg <= uidx_reg;
        end
        if (cmd.set_result)
        begin
            res_granted_reg <= cmd.res_granted;
            res_status_reg  <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            out_granted_reg <= res_granted_reg;
            out_addr_reg    <= res_granted_reg ? FIELD_ADDR_W'(grant_reg) : '0;
            out_status_reg  <= res_status_reg;
        end
    end

    // free table write mux
    always_comb
    begin
        fw_en   = cmd.load_store | cmd.free_update | cmd.free_move;
        fw_addr = idx_reg;
        fw_data = frd;
        if (cmd.load_store)
        begin
            fw_addr        = fcount_reg[FIDX_W-1:0];
            fw_data.start  = addr_reg;
            fw_data.length = size_reg;
        end
        else if (cmd.free_update)
        begin
            fw_data.start  = nstart_reg;
            fw_data.length = nlen_reg;
        end
        else if (cmd.free_move)
        begin
            fw_addr = idx_reg - 1'b1;
        end
    end

    // occupied table write mux
    always_comb
    begin
        uw_en   = cmd.ushift | cmd.uins;
        uw_addr = uidx_reg + 1'b1;
        uw_data = urd;
        if (cmd.uins)
        begin
            uw_addr        = pos_reg;
            uw_data.owner  = owner_reg;
            uw_data.start  = grant_reg;
            uw_data.length = size_reg;
        end
    end

    ffsa_ram #(
        .WIDTH ($bits(free_entry_t)),
        .DEPTH (FREE_ENTRIES)
    ) u_free_ram (
        .clk   (clk),
        .we    (fw_en),
        .waddr (fw_addr),
        .wdata (fw_data),
        .raddr (idx_next),
        .rdata (frd_bits)
    );

    ffsa_ram #(
        .WIDTH ($bits(used_entry_t)),
        .DEPTH (USED_ENTRIES)
    ) u_used_ram (
        .clk   (clk),
        .we    (uw_en),
        .waddr (uw_addr),
        .wdata (uw_data),
        .raddr (uidx_next),
        .rdata (urd_bits)
    );

    // status to controller
    always_comb
    begin
        stat.is_alloc     = (cmd_reg == CMD_ALLOC);
        stat.owner_zero   = (owner_reg == '0);
        stat.size_zero    = (size_reg == '0);
        stat.free_full    = (fcount_reg == FCNT_W'(FREE_ENTRIES));
        stat.free_empty   = (fcount_reg == '0);
        stat.used_full    = (ucount_reg == UCNT_W'(USED_ENTRIES));
        stat.fit          = (frd.length >= size_reg);
        stat.scan_last    = ((FCNT_W'(idx_reg) + 1'b1) == fcount_reg);
        stat.nlen_zero    = (nlen_reg == '0);
        stat.used_end     = (UCNT_W'(uidx_reg) == ucount_reg);
        stat.used_greater = (urd.start > grant_reg);
        stat.at_pos       = (uidx_reg == pos_reg);
        stat.out_free     = !out_valid_reg || out_ready;
    end

    // output: granted, grant address, status from the low bits up
    assign out_valid = out_valid_reg;
    assign out_data  = {{OUT_PAD_W{1'b0}}, out_status_reg, out_addr_reg, out_granted_reg};

endmodule

// File: design/first_fit_segment_allocator_top.sv
// Top level of the first-fit segment allocator: stream ports, controller and datapath.
//
// The block keeps a free segment table (load order) and an occupied table sorted
// by start address, each in a single-port-read RAM of FREE_ENTRIES and
// USED_ENTRIES entries. A transaction with tuser = 0 appends a free segment; with
// tuser = 1 it allocates the first free segment large enough, carving the grant
// from its low end. Every transaction returns exactly one result. The tables
// are walked one entry per clock through their RAM read ports, so one
// transaction is processed at a time. An allocation scans the free table to
// the hit, closes up the free table if the hit is used up, scans the occupied
// table for the insert position and moves the entries from there up one place.
// A new transaction is taken while the previous result still waits in the
// output register. There is no clearing pass after reset; the tables start
// empty.
module first_fit_segment_allocator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // owner_id[15:0], seg_address[47:16], seg_size[79:48]
    input  logic [ffsa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // command[0]: 0 load free segment, 1 allocate
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // granted[0], grant_address[32:1], status[35:33], zero pad above
    output logic [ffsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import ffsa_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    ffsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffsa_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_command (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule
